// ----- hw/rtl/tsf_pkg.sv -----
package tsf_pkg;

    // Fixed widths of the item fields and configuration registers.
    localparam int SAMPLE_BITS = 12;
    localparam int FIELD_COUNT = 5;
    localparam int COORD_W     = 16;
    localparam int SCALE_W     = 24;
    localparam int OFFSET_W    = 16;
    localparam int TOL_W       = 12;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Calibration arithmetic: Q4.20 factor times a mean, plus an offset.
    localparam int FRAC_BITS   = 20;
    localparam int PROD_W      = SCALE_W + SAMPLE_BITS + 1;
    localparam int TOTAL_W     = PROD_W + 1;

    // Rank of one sample among at most five, and the sum of the kept ones.
    localparam int RANK_W      = $clog2(FIELD_COUNT + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(FIELD_COUNT + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [COORD_W-1:0]     t_coord;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_REJECT = 2'd1,
        ST_PEN_UP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        GRP_FIRST_X  = 2'd0,
        GRP_FIRST_Y  = 2'd1,
        GRP_SECOND_X = 2'd2,
        GRP_SECOND_Y = 2'd3
    } t_group;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL = 3'd4;

    // Register values after reset.
    localparam logic [SCALE_W-1:0]  RST_X_SCALE   = 24'd37253;
    localparam logic [SCALE_W-1:0]  RST_Y_SCALE   = 24'd44763;
    localparam logic [OFFSET_W-1:0] RST_X_OFFSET  = 16'hFFF9;
    localparam logic [OFFSET_W-1:0] RST_Y_OFFSET  = 16'hFFFA;
    localparam logic [TOL_W-1:0]    RST_MATCH_TOL = 12'd50;

    localparam t_coord PEN_UP_COORD = 16'hFFFF;
    localparam t_coord COORD_MAX    = 16'hFFFF;

    // What the group sequencer hands to the calibration stages.
    typedef struct packed {
        logic    emit;
        t_status status;
        t_sample ax;
        t_sample ay;
    } t_seq_res;

endpackage

// ----- hw/rtl/tsf_if.sv -----
interface tsf_in_if;
    import tsf_pkg::*;

    logic    valid;
    logic    ready;
    logic    pen_down;
    t_sample sample_a;
    t_sample sample_b;
    t_sample sample_c;
    t_sample sample_d;
    t_sample sample_e;

    modport source (
        output valid, pen_down, sample_a, sample_b, sample_c, sample_d, sample_e,
        input  ready
    );
    modport sink (
        input  valid, pen_down, sample_a, sample_b, sample_c, sample_d, sample_e,
        output ready
    );
endinterface

interface tsf_out_if;
    import tsf_pkg::*;

    logic    valid;
    logic    ready;
    t_coord  x_coord;
    t_coord  y_coord;
    t_status status;

    modport source (
        output valid, x_coord, y_coord, status,
        input  ready
    );
    modport sink (
        input  valid, x_coord, y_coord, status,
        output ready
    );
endinterface

// ----- hw/rtl/tsf_lane.sv -----
module tsf_lane #(
    parameter int LANES = 5,
    parameter int IDX   = 0,
    parameter int TRIM  = 1
) (
    input  tsf_pkg::t_sample i_samples [tsf_pkg::FIELD_COUNT],
    output tsf_pkg::t_sample o_kept
);
    import tsf_pkg::*;

    logic [RANK_W-1:0] rank;

    // Rank of this sample in a stable sort: earlier equal samples count below it.
    always_comb begin
        rank = '0;
        for (int j = 0; j < LANES; j++) begin
            if (j < IDX) begin
                if (i_samples[j] <= i_samples[IDX]) rank = rank + RANK_W'(1);
            end else if (j > IDX) begin
                if (i_samples[j] < i_samples[IDX]) rank = rank + RANK_W'(1);
            end
        end
    end

    assign o_kept = (rank >= RANK_W'(TRIM) && rank < RANK_W'(LANES - TRIM))
                    ? i_samples[IDX] : '0;

endmodule

// ----- hw/rtl/tsf_merge.sv -----
module tsf_merge #(
    parameter int LANES = 5
) (
    input  tsf_pkg::t_sample           i_kept [LANES],
    output logic [tsf_pkg::SUM_W-1:0]  o_sum
);
    import tsf_pkg::*;

    always_comb begin
        o_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            o_sum = o_sum + SUM_W'(i_kept[k]);
        end
    end

endmodule

// ----- hw/rtl/tsf_seq.sv -----
module tsf_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_pen,
    input  tsf_pkg::t_sample         i_mean,
    input  logic [tsf_pkg::TOL_W-1:0] i_tol,
    output tsf_pkg::t_seq_res        o_res
);
    import tsf_pkg::*;

    t_group  r_group, n_group;
    t_sample r_first_x, r_first_y, r_second_x;
    t_sample dx, dy;
    logic [SAMPLE_BITS:0] sum_x, sum_y;

    always_comb begin
        n_group = r_group;
        if (!i_pen) begin
            n_group = GRP_FIRST_X;
        end else begin
            unique case (r_group)
                GRP_FIRST_X:  n_group = GRP_FIRST_Y;
                GRP_FIRST_Y:  n_group = GRP_SECOND_X;
                GRP_SECOND_X: n_group = GRP_SECOND_Y;
                GRP_SECOND_Y: n_group = GRP_FIRST_X;
                default:      n_group = GRP_FIRST_X;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group    <= GRP_FIRST_X;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_second_x <= '0;
        end else if (i_step) begin
            r_group <= n_group;
            if (i_pen) begin
                unique case (r_group)
                    GRP_FIRST_X:  r_first_x  <= i_mean;
                    GRP_FIRST_Y:  r_first_y  <= i_mean;
                    GRP_SECOND_X: r_second_x <= i_mean;
                    default: ;
                endcase
            end
        end
    end

    // The incoming mean is the second Y reading when the fourth group is here.
    assign dx    = (r_first_x > r_second_x) ? r_first_x - r_second_x
                                            : r_second_x - r_first_x;
    assign dy    = (r_first_y > i_mean) ? r_first_y - i_mean : i_mean - r_first_y;
    assign sum_x = {1'b0, r_first_x} + {1'b0, r_second_x};
    assign sum_y = {1'b0, r_first_y} + {1'b0, i_mean};

    always_comb begin
        o_res.emit   = 1'b0;
        o_res.status = ST_ACCEPT;
        o_res.ax     = sum_x[SAMPLE_BITS:1];
        o_res.ay     = sum_y[SAMPLE_BITS:1];
        if (!i_pen) begin
            o_res.emit   = 1'b1;
            o_res.status = ST_PEN_UP;
        end else if (r_group == GRP_SECOND_Y) begin
            o_res.emit   = 1'b1;
            o_res.status = (TOL_W'(dx) < i_tol && TOL_W'(dy) < i_tol) ? ST_ACCEPT
                                                                       : ST_REJECT;
        end
    end

endmodule

// ----- hw/rtl/tsf_calib.sv -----
module tsf_calib (
    input  logic signed [tsf_pkg::PROD_W-1:0]   i_prod,
    input  logic        [tsf_pkg::OFFSET_W-1:0] i_offset,
    output tsf_pkg::t_coord                     o_coord
);
    import tsf_pkg::*;

    logic signed [TOTAL_W-1:0] total;
    logic [TOTAL_W-FRAC_BITS-1:0] whole;

    assign total = TOTAL_W'(i_prod) + (TOTAL_W'($signed(i_offset)) <<< FRAC_BITS);
    assign whole = total[TOTAL_W-1:FRAC_BITS];

    // Non-positive totals clamp to zero, anything past the coordinate range clamps high.
    always_comb begin
        if (total <= 0) begin
            o_coord = '0;
        end else if (whole[TOTAL_W-FRAC_BITS-1:COORD_W] != '0) begin
            o_coord = COORD_MAX;
        end else begin
            o_coord = whole[COORD_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/touch_sample_filter_core.sv -----
// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    pen_down, sample_a .. sample_e (12 bits each)
// o_res     out        valid/ready    x_coord, y_coord (16 bits), status (2 bits)
// i_cfg_*   in         write enable   index 0..4, data up to 24 bits
//
// One item is taken in every clock cycle unless a stall on o_res reaches the input. The
// rate is set by the single sequencer stage, which sees one group per cycle when not
// stalled. The synchronous active-low reset clears all valid bits, the group sequence,
// the held coordinates and loads the calibration defaults. A stall on o_res fills the
// empty stages first, so items keep being accepted until every stage holds one.

module touch_sample_filter_core #(
    parameter int SAMPLES_PER_GROUP = 5,
    parameter int TRIM_EACH_END     = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tsf_in_if.sink                        i_in,
    tsf_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsf_pkg::*;

    // Only five sample fields exist; a trim that would leave nothing is reduced.
    localparam int N_USED    = (SAMPLES_PER_GROUP > FIELD_COUNT) ? FIELD_COUNT
                                                                 : SAMPLES_PER_GROUP;
    localparam int TRIM_USED = (2 * TRIM_EACH_END >= N_USED) ? (N_USED - 1) / 2
                                                             : TRIM_EACH_END;
    localparam int KEEP      = N_USED - 2 * TRIM_USED;

    // The mean divides by a constant count through a reciprocal multiply.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / KEEP + 1);
    localparam int QUOT_W      = SUM_W + RECIP_W;

    // Configuration registers.
    logic signed [SCALE_W-1:0] r_x_scale, r_y_scale;
    logic [OFFSET_W-1:0]       r_x_offset, r_y_offset;
    logic [TOL_W-1:0]          r_tol;

    // Pipeline valid bits and the ready chain that lets bubbles collapse.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_ov;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

    // Stage payloads.
    logic        r_s1_pen, r_s2_pen, r_s3_pen, r_s4_pen;
    t_sample     r_s1_smp [FIELD_COUNT];
    t_sample     r_s2_kept [N_USED];
    logic [SUM_W-1:0] r_s3_sum;
    t_sample     r_s4_mean;
    t_seq_res    r_s5;
    t_status     r_s6_status;
    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;

    t_coord      r_held_x, r_held_y;
    t_coord      r_out_x, r_out_y;
    t_status     r_out_status;

    t_sample     w_kept [N_USED];
    logic [SUM_W-1:0]  w_sum;
    logic [QUOT_W-1:0] w_quot;
    t_seq_res    w_seq;
    t_coord      w_cal_x, w_cal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale  <= RST_X_SCALE;
            r_y_scale  <= RST_Y_SCALE;
            r_x_offset <= RST_X_OFFSET;
            r_y_offset <= RST_Y_OFFSET;
            r_tol      <= RST_MATCH_TOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_SCALE:   r_x_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_Y_SCALE:   r_y_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_X_OFFSET:  r_x_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_Y_OFFSET:  r_y_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_MATCH_TOL: r_tol      <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on this cycle.
    assign rdy_out = !r_ov || o_res.ready;
    assign rdy6    = !r_v6 || rdy_out;
    assign rdy5    = !r_v5 || rdy6;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign i_in.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1)    r_v1 <= i_in.valid;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
            if (rdy4)    r_v4 <= r_v3;
            // Groups one to three end in the sequencer and leave a bubble behind.
            if (rdy5)    r_v5 <= r_v4 && w_seq.emit;
            if (rdy6)    r_v6 <= r_v5;
            if (rdy_out) r_ov <= r_v6;
        end
    end

    // Stage 1: the accepted item.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_pen    <= i_in.pen_down;
            r_s1_smp[0] <= i_in.sample_a;
            r_s1_smp[1] <= i_in.sample_b;
            r_s1_smp[2] <= i_in.sample_c;
            r_s1_smp[3] <= i_in.sample_d;
            r_s1_smp[4] <= i_in.sample_e;
        end
    end

    // Stage 2: each lane ranks its own sample and keeps it if it survives the trim.
    for (genvar g = 0; g < N_USED; g++) begin : g_lane
        tsf_lane #(
            .LANES (N_USED),
            .IDX   (g),
            .TRIM  (TRIM_USED)
        ) u_lane (
            .i_samples (r_s1_smp),
            .o_kept    (w_kept[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_pen <= r_s1_pen;
            for (int k = 0; k < N_USED; k++) begin
                r_s2_kept[k] <= w_kept[k];
            end
        end
    end

    // Stage 3: the merge adds up what the lanes kept.
    tsf_merge #(
        .LANES (N_USED)
    ) u_merge (
        .i_kept (r_s2_kept),
        .o_sum  (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_pen <= r_s2_pen;
            r_s3_sum <= w_sum;
        end
    end

    // Stage 4: truncated mean. The reciprocal is exact for every reachable sum.
    assign w_quot = QUOT_W'(r_s3_sum) * QUOT_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_pen  <= r_s3_pen;
            r_s4_mean <= w_quot[RECIP_SHIFT +: SAMPLE_BITS];
        end
    end

    // Stage 5: the group sequence steps once for every item that leaves stage 4.
    tsf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (rdy5 && r_v4),
        .i_pen   (r_s4_pen),
        .i_mean  (r_s4_mean),
        .i_tol   (r_tol),
        .o_res   (w_seq)
    );

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5 <= w_seq;
        end
    end

    // Stage 6: the calibration products.
    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_s6_status <= r_s5.status;
            r_prod_x    <= r_x_scale * $signed({1'b0, r_s5.ax});
            r_prod_y    <= r_y_scale * $signed({1'b0, r_s5.ay});
        end
    end

    tsf_calib u_calib_x (
        .i_prod   (r_prod_x),
        .i_offset (r_x_offset),
        .o_coord  (w_cal_x)
    );

    tsf_calib u_calib_y (
        .i_prod   (r_prod_y),
        .i_offset (r_y_offset),
        .o_coord  (w_cal_y)
    );

    // Output stage. The held coordinates live here, so every result sees the
    // updates of all items ahead of it in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (rdy_out && r_v6) begin
            case (r_s6_status)
                ST_PEN_UP: begin
                    r_held_x <= PEN_UP_COORD;
                    r_held_y <= PEN_UP_COORD;
                end
                ST_ACCEPT: begin
                    r_held_x <= w_cal_x;
                    r_held_y <= w_cal_y;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_v6) begin
            r_out_status <= r_s6_status;
            case (r_s6_status)
                ST_PEN_UP: begin
                    r_out_x <= PEN_UP_COORD;
                    r_out_y <= PEN_UP_COORD;
                end
                ST_ACCEPT: begin
                    r_out_x <= w_cal_x;
                    r_out_y <= w_cal_y;
                end
                default: begin
                    r_out_x <= r_held_x;
                    r_out_y <= r_held_y;
                end
            endcase
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.x_coord = r_out_x;
    assign o_res.y_coord = r_out_y;
    assign o_res.status  = r_out_status;

endmodule

// ----- hw/rtl/tsf_checker.sv -----
module tsf_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  tsf_pkg::t_coord              i_x,
    input  tsf_pkg::t_coord              i_y,
    input  logic [tsf_pkg::STATUS_W-1:0] i_status
);
    import tsf_pkg::*;

    t_coord r_last_x, r_last_y;

    // Coordinates of the most recent delivered result, zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_x <= i_x;
            r_last_y <= i_y;
        end
    end

    a_pen_up_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_PEN_UP) |-> (i_x == PEN_UP_COORD && i_y == PEN_UP_COORD))
        else $error("pen-up result without released coordinates");

    a_reject_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_REJECT) |-> (i_x == r_last_x && i_y == r_last_y))
        else $error("rejected result does not repeat the previous coordinates");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_x) && $stable(i_y) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind touch_sample_filter_core tsf_checker u_tsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_x         (o_res.x_coord),
    .i_y         (o_res.y_coord),
    .i_status    (o_res.status)
);
